FILE: hdl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg
// Shared widths, command and status codes, and the cell control type for the
// output-restricted deque.
// ----------------------------------------------------------------------------
package odq_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int ST_W   = 2;
	localparam int FILL_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic shift_r;
		logic shift_l;
		logic load;
	} odq_cell_ctl_t;

endpackage

FILE: hdl/output_restricted_deque_unit.sv
// ----------------------------------------------------------------------------
// output_restricted_deque_unit
// Deque of DEPTH signed 32-bit entries: push at back, push at front, pop at
// the front. Command channel (cmd_valid/cmd_stall) carries command and
// data_in; response channel (rsp_valid/rsp_stall) returns one beat per
// command with status, data_out and fill_count.
// The response is registered: rsp_valid rises in the cycle after command accept. Throughput
// is one command per cycle while cmd_stall is low; the cells update in the accept cycle.
// A full push or an empty pop reports its status and changes nothing.
// While the response register holds a beat that rsp_stall keeps, cmd_stall
// is raised; the pending beat holds until taken.
// Reset empties the deque and drops any pending response; entry contents
// are not cleared.
// ----------------------------------------------------------------------------
module output_restricted_deque_unit
	import odq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [DATA_W-1:0]  data_in,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [ST_W-1:0]           status,
	output logic signed [DATA_W-1:0]  data_out,
	output logic [FILL_W-1:0]         fill_count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]           count_q;
	logic [CW-1:0]           count_nxt;
	logic [DATA_W-1:0]       cell_q [DEPTH];
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    push_back;
	logic                    push_front;
	logic                    pop;
	logic [ST_W-1:0]         st_nxt;
	logic [DATA_W-1:0]       dout_nxt;
	logic [CW+FILL_W-1:0]    fill_ext;
	logic                    rsp_valid_q;
	logic [ST_W-1:0]         status_q;
	logic [DATA_W-1:0]       data_out_q;
	logic [FILL_W-1:0]       fill_q;

	assign accept = cmd_valid && !cmd_stall;
	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);

	always_comb begin
		push_back  = 1'b0;
		push_front = 1'b0;
		pop        = 1'b0;
		st_nxt     = ST_OK;
		dout_nxt   = '0;
		case (command)
			CMD_PUSH_BACK: begin
				if (full) st_nxt = ST_FULL;
				else push_back = accept;
			end
			CMD_PUSH_FRONT: begin
				if (full) st_nxt = ST_FULL;
				else push_front = accept;
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					pop      = accept;
					dout_nxt = cell_q[0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (push_back || push_front) count_nxt = count_q + 1'b1;
		else if (pop) count_nxt = count_q - 1'b1;
	end

	assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		odq_cell_ctl_t     ctl;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;

		assign ctl.shift_r = push_front;
		assign ctl.shift_l = pop;
		assign ctl.load    = push_back && (count_q == CW'(i));

		if (i == 0) begin : g_first
			assign left = data_in;
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = data_in;
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end

		odq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left      (left),
			.right     (right),
			.push_data (data_in),
			.data      (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= st_nxt;
			data_out_q <= dout_nxt;
			fill_q     <= fill_ext[FILL_W-1:0];
		end
	end

	assign cmd_stall  = rsp_valid_q && rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign data_out   = data_out_q;
	assign fill_count = fill_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("deque count beyond depth");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_POP_FRONT && empty |=> status == ST_EMPTY && rsp_valid)
		else $error("empty pop not reported");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_back || push_front |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("push did not grow count");

	a_dout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> data_out == '0)
		else $error("data on refused beat");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> rsp_valid && rsp_stall)
		else $error("command stall without held response");
`endif

endmodule

FILE: hdl/odq_cell.sv
// ----------------------------------------------------------------------------
// odq_cell
// One slot of the deque chain. Takes its left neighbor on a front push, its
// right neighbor on a pop, or the pushed value on a back push into this slot.
// ----------------------------------------------------------------------------
module odq_cell
	import odq_pkg::*;
(
	input  logic                clk,
	input  odq_cell_ctl_t       ctl,
	input  logic [DATA_W-1:0]   left,
	input  logic [DATA_W-1:0]   right,
	input  logic [DATA_W-1:0]   push_data,
	output logic [DATA_W-1:0]   data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_r) begin
			data_q <= left;
		end else if (ctl.shift_l) begin
			data_q <= right;
		end else if (ctl.load) begin
			data_q <= push_data;
		end
	end

	assign data = data_q;

endmodule
